### src/qdi_pkg.sv
// Shared types, constants and the transition lookup for the quadrature decoder.
package qdi_pkg;

    localparam int unsigned CNT_W          = 32;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam logic [1:0]  START_AB_RESET = 2'd3;

    // Step kind decoded from one event
    typedef enum logic [2:0] {
        STEP_NONE  = 3'd0,
        STEP_FWD   = 3'd1,
        STEP_REV   = 3'd2,
        STEP_ERR   = 3'd3,
        STEP_INDEX = 3'd4
    } t_step;

    // Classified event handed from the front to the back
    typedef struct packed {
        t_step kind;
        logic  ack;
    } t_op;

    // x4 transition table: previous state in the high bits, new state in the low bits
    function automatic t_step step_lookup(input logic [1:0] prev_ab, input logic [1:0] now_ab);
        t_step kind;
        unique case ({prev_ab, now_ab})
            4'b00_00: kind = STEP_NONE;
            4'b00_01: kind = STEP_REV;
            4'b00_10: kind = STEP_FWD;
            4'b00_11: kind = STEP_ERR;
            4'b01_00: kind = STEP_FWD;
            4'b01_01: kind = STEP_NONE;
            4'b01_10: kind = STEP_ERR;
            4'b01_11: kind = STEP_REV;
            4'b10_00: kind = STEP_REV;
            4'b10_01: kind = STEP_ERR;
            4'b10_10: kind = STEP_NONE;
            4'b10_11: kind = STEP_FWD;
            4'b11_00: kind = STEP_ERR;
            4'b11_01: kind = STEP_FWD;
            4'b11_10: kind = STEP_REV;
            4'b11_11: kind = STEP_NONE;
            default:  kind = STEP_NONE;
        endcase
        return kind;
    endfunction

endpackage

### src/quadrature_decoder_with_index_top.sv
// Top level of the x4 quadrature decoder with index pulse measurement.
//
// Each input beat is one encoder event, and each yields exactly one result beat with
// the counters after that event. The block takes one beat per clock cycle while the
// queue is not full; the accepting edge writes the classified event into the queue,
// and the edge that pops it from the queue loads the counters and the result
// register in the back. The queue of QUEUE_DEPTH entries lets the input side keep
// going while a result beat is stalled, until the queue fills. Writing the config
// register loads the channel state at once.
module quadrature_decoder_with_index_top #(
    parameter int unsigned QUEUE_DEPTH = qdi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [0] chan_a, [1] chan_b, [2] err_ack, [7:3] zero
    input  logic         s_axis_tuser,   // [0] func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // [31:0] net_count, [63:32] fwd_count,
                                         // [95:64] rev_count, [127:96] err_count,
                                         // [159:128] index_pulses
    output logic         m_axis_tuser    // [0] in_error
);

    qdi_pkg::t_op front_op;
    qdi_pkg::t_op queue_op;
    logic         push, pop, q_full, q_empty;
    logic [qdi_pkg::CNT_W-1:0] net_count, fwd_count, rev_count, err_count, index_pulses;

    qdi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_chan_a    (s_axis_tdata[0]),
        .i_chan_b    (s_axis_tdata[1]),
        .i_err_ack   (s_axis_tdata[2]),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_op        (front_op)
    );

    qdi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_op    (queue_op)
    );

    qdi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_op           (queue_op),
        .o_pop          (pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_net_count    (net_count),
        .o_fwd_count    (fwd_count),
        .o_rev_count    (rev_count),
        .o_err_count    (err_count),
        .o_index_pulses (index_pulses),
        .o_in_error     (m_axis_tuser)
    );

    assign m_axis_tdata = {index_pulses, err_count, rev_count, fwd_count, net_count};

endmodule

### src/qdi_front.sv
// Front end: accepts event beats, tracks the channel state and classifies each event.
module qdi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_func,
    input  logic          i_chan_a,
    input  logic          i_chan_b,
    input  logic          i_err_ack,
    input  logic          i_q_full,
    output logic          o_push,
    output qdi_pkg::t_op  o_op
);

    logic [1:0] r_last_ab;
    logic [1:0] n_last_ab;
    logic [1:0] now_ab;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign now_ab  = {i_chan_b, i_chan_a};

    // Classify the event against the previous channel state, or as an index event when func is set
    always_comb begin
        o_op.ack = i_err_ack;
        if (i_func) begin
            o_op.kind = qdi_pkg::STEP_INDEX;
        end else begin
            o_op.kind = qdi_pkg::step_lookup(r_last_ab, now_ab);
        end
    end

    // Advance the channel state on channel beats, load it on a config write
    always_comb begin
        n_last_ab = r_last_ab;
        if (i_cfg_we) begin
            n_last_ab = i_cfg_wdata;
        end else if (o_push && !i_func) begin
            n_last_ab = now_ab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ab <= qdi_pkg::START_AB_RESET;
        end else begin
            r_last_ab <= n_last_ab;
        end
    end

endmodule

### src/qdi_queue.sv
// Small FIFO of classified events between the front and the back.
module qdi_queue #(
    parameter int unsigned DEPTH = qdi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qdi_pkg::t_op  i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output qdi_pkg::t_op  o_op
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qdi_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write the storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

### src/qdi_back.sv
// Back end: applies classified events to the counters and holds the result beat.
module qdi_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  qdi_pkg::t_op                i_op,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [qdi_pkg::CNT_W-1:0]   o_net_count,
    output logic [qdi_pkg::CNT_W-1:0]   o_fwd_count,
    output logic [qdi_pkg::CNT_W-1:0]   o_rev_count,
    output logic [qdi_pkg::CNT_W-1:0]   o_err_count,
    output logic [qdi_pkg::CNT_W-1:0]   o_index_pulses,
    output logic                        o_in_error
);

    localparam int unsigned W = qdi_pkg::CNT_W;

    logic [W-1:0] r_net, r_fwd, r_rev, r_err, r_ppr, r_diff;
    logic [W-1:0] n_net, n_fwd, n_rev, n_err, n_ppr, n_diff;
    logic         r_first, n_first;
    logic         r_flag, n_flag, flag_now;
    logic [W-1:0] diff_abs;
    logic         r_out_valid;

    // Pop when the output register is free or being drained
    assign o_pop   = !i_q_empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;

    // Magnitude of net movement since the last index
    assign diff_abs = r_diff[W-1] ? (~r_diff + 1'b1) : r_diff;

    // Apply one event; the difference to the last index is tracked alongside
    always_comb begin
        n_net   = r_net;
        n_fwd   = r_fwd;
        n_rev   = r_rev;
        n_err   = r_err;
        n_ppr   = r_ppr;
        n_diff  = r_diff;
        n_first = r_first;
        flag_now = r_flag;
        unique case (i_op.kind)
            qdi_pkg::STEP_FWD: begin
                n_net  = r_net + 1'b1;
                n_fwd  = r_fwd + 1'b1;
                n_diff = r_diff + 1'b1;
            end
            qdi_pkg::STEP_REV: begin
                n_net  = r_net - 1'b1;
                n_rev  = r_rev + 1'b1;
                n_diff = r_diff - 1'b1;
            end
            qdi_pkg::STEP_ERR: begin
                n_err    = r_err + 1'b1;
                flag_now = 1'b1;
            end
            qdi_pkg::STEP_INDEX: begin
                if (!r_first) begin
                    n_ppr = diff_abs;
                end
                n_first = 1'b0;
                n_diff  = '0;
            end
            default: begin
            end
        endcase
        n_flag = flag_now && !i_op.ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net       <= '0;
            r_fwd       <= '0;
            r_rev       <= '0;
            r_err       <= '0;
            r_ppr       <= '0;
            r_diff      <= '0;
            r_first     <= 1'b1;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_net   <= n_net;
                r_fwd   <= n_fwd;
                r_rev   <= n_rev;
                r_err   <= n_err;
                r_ppr   <= n_ppr;
                r_diff  <= n_diff;
                r_first <= n_first;
                r_flag  <= n_flag;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_net_count    <= n_net;
            o_fwd_count    <= n_fwd;
            o_rev_count    <= n_rev;
            o_err_count    <= n_err;
            o_index_pulses <= n_ppr;
            o_in_error     <= flag_now;
        end
    end

endmodule

### src/qdi_checker.sv
// Port-level checks for the quadrature decoder, bound to the top level.
module qdi_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    logic        beat;
    logic [31:0] r_last_err;

    assign beat = m_axis_tvalid && m_axis_tready;

    // Track the error count of the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
        end else if (beat) begin
            r_last_err <= m_axis_tdata[127:96];
        end
    end

    // Stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // No result right after reset
    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Net position always equals forward minus reverse
    a_net: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat |-> m_axis_tdata[31:0] == m_axis_tdata[63:32] - m_axis_tdata[95:64])
        else $error("net count out of step with forward and reverse counts");

    // Error count advances by at most one per beat
    a_err_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat |-> m_axis_tdata[127:96] == r_last_err
                 || m_axis_tdata[127:96] == r_last_err + 32'd1)
        else $error("error count jumped");

    // A counted error always shows the error flag
    a_err_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat && m_axis_tdata[127:96] != r_last_err |-> m_axis_tuser)
        else $error("error counted without error flag");

endmodule

bind quadrature_decoder_with_index_top qdi_checker u_qdi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
